FILE: rtl/gelu_tanh_activation_core_assert.svh
// Assertion macros used by the GELU activation core RTL.
// Depends on clk and rst_n being visible where a macro is used.
`ifndef GELU_TANH_ACTIVATION_CORE_ASSERT_SVH
`define GELU_TANH_ACTIVATION_CORE_ASSERT_SVH

// Same-cycle implication, checked out of reset
`define GTAC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gtac assertion failed");

// Next-cycle implication, checked out of reset
`define GTAC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gtac assertion failed");

`endif

FILE: rtl/gtac_pkg.sv
// Shared constants, pipeline control type and tanh table builder for the
// GELU activation core. No dependencies.
package gtac_pkg;

    // Default configuration
    localparam int DATA_WIDTH_DEF    = 16;
    localparam int FRAC_BITS_DEF     = 8;
    localparam int TANH_SEGMENTS_DEF = 64;
    localparam int TANH_SEG_MAX      = 1024;

    // Internal working format: unsigned Q.24
    localparam int WF      = 24;
    localparam int A_W     = 26;    // |u| < 4
    localparam int A2_W    = 28;    // a^2 < 16
    localparam int A3_W    = 30;    // a^3 < 64
    localparam int CUBE_W  = 26;    // 0.044715*a^3 < 2.87
    localparam int INNER_W = 27;    // a + cube < 6.87
    localparam int Z_W     = 27;    // z < 5.49
    localparam int R_W     = 26;    // interpolation fraction
    localparam int T_W     = 25;    // tanh in [0,1]
    localparam int FAC_W   = 26;    // 1 +/- tanh in [0,2]

    localparam logic [23:0] C_SCALE = 24'd13386282;   // 0.7978845608
    localparam logic [19:0] C_CUBE  = 20'd750193;     // 0.044715
    localparam logic [T_W-1:0] ONE_WF = T_W'(1) << WF;

    localparam logic [63:0] Q30        = 64'd1 << 30;
    localparam logic [63:0] EXP_M1_Q30 = 64'd395007542;

    // Per-stage control that travels with each transaction
    typedef struct packed {
        logic valid;
        logic neg;
        logic big;
    } ctrl_t;

    typedef logic [T_W-1:0] tanh_tab_t [0:TANH_SEG_MAX];

    // Restoring long division, used only while building the table
    function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
        logic [63:0] q;
        logic [64:0] rem;
        q   = '0;
        rem = '0;
        for (int b = 63; b >= 0; b--)
        begin
            rem = {rem[63:0], n[b]};
            if (rem >= {1'b0, d})
            begin
                rem  = rem - {1'b0, d};
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // e^(-f) for f in [0,1), Q.30, Taylor series through the fourteenth power
    function automatic logic [63:0] exp_neg_frac(input logic [63:0] f);
        logic [63:0] term;
        longint      sum;
        term = Q30;
        sum  = longint'(Q30);
        for (int k = 1; k <= 14; k++)
        begin
            term = udiv64((term * f) >> 30, 64'(k));
            if (k % 2 == 1)
                sum = sum - longint'(term);
            else
                sum = sum + longint'(term);
        end
        if (sum < 0)
            sum = 0;
        return 64'(sum);
    endfunction

    // tanh at the segment ends over [0,4), Q.24, forced non-decreasing
    function automatic tanh_tab_t tanh_table(input int seg);
        tanh_tab_t   tab;
        logic [63:0] t30;
        logic [63:0] n;
        logic [63:0] e;
        logic [63:0] num;
        logic [63:0] den;
        logic [63:0] v;
        for (int i = 0; i <= TANH_SEG_MAX; i++)
        begin
            if (i <= seg)
            begin
                t30 = udiv64(64'(i) * (64'd8 << 30), 64'(seg));
                n   = t30 >> 30;
                e   = exp_neg_frac(t30 & (Q30 - 64'd1));
                for (int j = 0; j < int'(n); j++)
                    e = (e * EXP_M1_Q30 + (Q30 >> 1)) >> 30;
                if (e > Q30)
                    e = Q30;
                num = (Q30 - e) << WF;
                den = Q30 + e;
                v   = udiv64(num + (den >> 1), den);
                if (i > 0 && v < 64'(tab[i-1]))
                    v = 64'(tab[i-1]);
                tab[i] = T_W'(v);
            end
            else
            begin
                tab[i] = '0;
            end
        end
        return tab;
    endfunction

endpackage

FILE: rtl/gtac_poly.sv
// Front pipeline of the GELU core: input capture, cube and tanh argument.
// Five register stages. Depends on gtac_pkg.
module gtac_poly #(
    parameter int DATA_WIDTH = gtac_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = gtac_pkg::FRAC_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic        [DATA_WIDTH-1:0]  in_sample,
    output gtac_pkg::ctrl_t               ctrl_out,
    output logic        [DATA_WIDTH-1:0]  mag_out,
    output logic        [gtac_pkg::A_W-1:0] a_out,
    output logic        [gtac_pkg::Z_W-1:0] z_out
);

    localparam int A_W  = gtac_pkg::A_W;
    localparam int WF   = gtac_pkg::WF;
    localparam int SQ_W = 2 * A_W + 1;
    localparam int CU_W = gtac_pkg::A2_W + A_W + 1;
    localparam int CB_W = gtac_pkg::A3_W + 21;
    localparam int ZP_W = gtac_pkg::INNER_W + 25;

    gtac_pkg::ctrl_t ctrl1_reg, ctrl2_reg, ctrl3_reg, ctrl4_reg, ctrl5_reg;
    gtac_pkg::ctrl_t ctrl1_next;
    logic [DATA_WIDTH-1:0] mag1_reg, mag2_reg, mag3_reg, mag4_reg, mag5_reg;
    logic [DATA_WIDTH-1:0] mag1_next;
    logic [A_W-1:0] a1_reg, a2p_reg, a3p_reg, a4p_reg, a5p_reg;
    logic [A_W-1:0] a1_next;
    logic [gtac_pkg::A2_W-1:0]    sq2_reg, sq2_next;
    logic [gtac_pkg::A3_W-1:0]    cu3_reg, cu3_next;
    logic [gtac_pkg::INNER_W-1:0] inner4_reg, inner4_next;
    logic [gtac_pkg::Z_W-1:0]     z5_reg, z5_next;
    logic [DATA_WIDTH-1:0] raw;

    // Take magnitude and flag inputs whose magnitude is four or more
    always_comb
    begin
        raw              = in_sample;
        ctrl1_next.valid = in_valid;
        ctrl1_next.neg   = raw[DATA_WIDTH-1];
        mag1_next        = raw[DATA_WIDTH-1] ? ((~raw) + DATA_WIDTH'(1)) : raw;
        ctrl1_next.big   = (64'(mag1_next) >= (64'd4 << FRAC_BITS));
        a1_next          = A_W'(64'(mag1_next) << (WF - FRAC_BITS));
    end

    // Square, cube, inner sum and scale, each rounded half up
    assign sq2_next = gtac_pkg::A2_W'(
        (SQ_W'(a1_reg) * SQ_W'(a1_reg) + (SQ_W'(1) << (WF - 1))) >> WF);
    assign cu3_next = gtac_pkg::A3_W'(
        (CU_W'(sq2_reg) * CU_W'(a2p_reg) + (CU_W'(1) << (WF - 1))) >> WF);
    assign inner4_next = gtac_pkg::INNER_W'(a3p_reg) + gtac_pkg::INNER_W'(
        (CB_W'(gtac_pkg::C_CUBE) * CB_W'(cu3_reg) + (CB_W'(1) << (WF - 1))) >> WF);
    assign z5_next = gtac_pkg::Z_W'(
        (ZP_W'(gtac_pkg::C_SCALE) * ZP_W'(inner4_reg) + (ZP_W'(1) << (WF - 1))) >> WF);

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl1_reg <= '0;
            ctrl2_reg <= '0;
            ctrl3_reg <= '0;
            ctrl4_reg <= '0;
            ctrl5_reg <= '0;
        end
        else
        begin
            ctrl1_reg <= ctrl1_next;
            ctrl2_reg <= ctrl1_reg;
            ctrl3_reg <= ctrl2_reg;
            ctrl4_reg <= ctrl3_reg;
            ctrl5_reg <= ctrl4_reg;
        end
    end

    // Advance payload
    always_ff @(posedge clk)
    begin
        mag1_reg   <= mag1_next;
        a1_reg     <= a1_next;
        mag2_reg   <= mag1_reg;
        a2p_reg    <= a1_reg;
        sq2_reg    <= sq2_next;
        mag3_reg   <= mag2_reg;
        a3p_reg    <= a2p_reg;
        cu3_reg    <= cu3_next;
        mag4_reg   <= mag3_reg;
        a4p_reg    <= a3p_reg;
        inner4_reg <= inner4_next;
        mag5_reg   <= mag4_reg;
        a5p_reg    <= a4p_reg;
        z5_reg     <= z5_next;
    end

    assign ctrl_out = ctrl5_reg;
    assign mag_out  = mag5_reg;
    assign a_out    = a5p_reg;
    assign z_out    = z5_reg;

endmodule

FILE: rtl/gtac_tanh.sv
// Piecewise-linear tanh over [0,4) and the 1 +/- tanh factor.
// Three register stages. Depends on gtac_pkg.
module gtac_tanh #(
    parameter int DATA_WIDTH    = gtac_pkg::DATA_WIDTH_DEF,
    parameter int TANH_SEGMENTS = gtac_pkg::TANH_SEGMENTS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  gtac_pkg::ctrl_t                 ctrl_in,
    input  logic [DATA_WIDTH-1:0]           mag_in,
    input  logic [gtac_pkg::A_W-1:0]        a_in,
    input  logic [gtac_pkg::Z_W-1:0]        z_in,
    output gtac_pkg::ctrl_t                 ctrl_out,
    output logic [DATA_WIDTH-1:0]           mag_out,
    output logic [gtac_pkg::A_W-1:0]        a_out,
    output logic [gtac_pkg::FAC_W-1:0]      fac_out
);

    localparam int A_W    = gtac_pkg::A_W;
    localparam int T_W    = gtac_pkg::T_W;
    localparam int R_W    = gtac_pkg::R_W;
    localparam int FAC_W  = gtac_pkg::FAC_W;
    localparam int IDXP_W = $clog2(TANH_SEGMENTS + 1);
    localparam int IDX_W  = $clog2(TANH_SEGMENTS);
    localparam int P_W    = R_W + IDXP_W;
    localparam int M_W    = T_W + R_W;
    localparam gtac_pkg::tanh_tab_t TAB_FULL = gtac_pkg::tanh_table(TANH_SEGMENTS);

    logic [T_W-1:0] tab [0:TANH_SEGMENTS];

    gtac_pkg::ctrl_t ctrl6_reg, ctrl7_reg, ctrl8_reg;
    logic [DATA_WIDTH-1:0] mag6_reg, mag7_reg, mag8_reg;
    logic [A_W-1:0]    a6_reg, a7_reg, a8_reg;
    logic              zsat6_reg, zsat7_reg;
    logic [IDX_W-1:0]  idx6_reg, idx6_next;
    logic [R_W-1:0]    r6_reg, r6_next, r7_reg;
    logic [P_W-1:0]    pos;
    logic [IDXP_W-1:0] idx_lo, idx_hi;
    logic [T_W-1:0]    lo7_reg, lo7_next, diff7_reg, diff7_next;
    logic [T_W-1:0]    tval;
    logic [FAC_W-1:0]  fac8_reg, fac8_next;

    // Constant table of segment ends
    for (genvar g = 0; g <= TANH_SEGMENTS; g++)
    begin : g_tab
        assign tab[g] = TAB_FULL[g];
    end

    // Split the argument into segment index and fraction
    assign pos       = P_W'(z_in[R_W-1:0]) * P_W'(TANH_SEGMENTS);
    assign idx6_next = IDX_W'(pos >> R_W);
    assign r6_next   = pos[R_W-1:0];

    // Fetch both segment ends
    assign idx_lo     = IDXP_W'(idx6_reg);
    assign idx_hi     = idx_lo + IDXP_W'(1);
    assign lo7_next   = tab[idx_lo];
    assign diff7_next = tab[idx_hi] - tab[idx_lo];

    // Interpolate, saturate to one past the table, fold in the sign
    always_comb
    begin
        tval = zsat7_reg ? gtac_pkg::ONE_WF
                         : lo7_reg + T_W'((M_W'(diff7_reg) * M_W'(r7_reg)) >> R_W);
        fac8_next = ctrl7_reg.neg ? (FAC_W'(gtac_pkg::ONE_WF) - FAC_W'(tval))
                                  : (FAC_W'(gtac_pkg::ONE_WF) + FAC_W'(tval));
    end

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl6_reg <= '0;
            ctrl7_reg <= '0;
            ctrl8_reg <= '0;
        end
        else
        begin
            ctrl6_reg <= ctrl_in;
            ctrl7_reg <= ctrl6_reg;
            ctrl8_reg <= ctrl7_reg;
        end
    end

    // Advance payload
    always_ff @(posedge clk)
    begin
        mag6_reg  <= mag_in;
        a6_reg    <= a_in;
        zsat6_reg <= z_in[gtac_pkg::Z_W-1];
        idx6_reg  <= idx6_next;
        r6_reg    <= r6_next;
        mag7_reg  <= mag6_reg;
        a7_reg    <= a6_reg;
        zsat7_reg <= zsat6_reg;
        r7_reg    <= r6_reg;
        lo7_reg   <= lo7_next;
        diff7_reg <= diff7_next;
        mag8_reg  <= mag7_reg;
        a8_reg    <= a7_reg;
        fac8_reg  <= fac8_next;
    end

    assign ctrl_out = ctrl8_reg;
    assign mag_out  = mag8_reg;
    assign a_out    = a8_reg;
    assign fac_out  = fac8_reg;

endmodule

FILE: rtl/gtac_out.sv
// Output stages of the GELU core: final product, rounding, saturation, sign.
// Two register stages. Depends on gtac_pkg and the assertion macro header.
`include "gelu_tanh_activation_core_assert.svh"

module gtac_out #(
    parameter int DATA_WIDTH = gtac_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = gtac_pkg::FRAC_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  gtac_pkg::ctrl_t                   ctrl_in,
    input  logic        [DATA_WIDTH-1:0]      mag_in,
    input  logic        [gtac_pkg::A_W-1:0]   a_in,
    input  logic        [gtac_pkg::FAC_W-1:0] fac_in,
    output logic                              done,
    output logic signed [DATA_WIDTH-1:0]      activation_out
);

    localparam int PROD_W = gtac_pkg::A_W + gtac_pkg::FAC_W;
    localparam int SH     = 2 * gtac_pkg::WF + 1 - FRAC_BITS;
    localparam int RES_W  = PROD_W + 1 - SH;
    localparam int SAT_W  = ((DATA_WIDTH > RES_W) ? DATA_WIDTH : RES_W) + 1;

    gtac_pkg::ctrl_t       ctrl9_reg;
    logic [DATA_WIDTH-1:0] mag9_reg;
    logic [PROD_W-1:0]     prod9_reg, prod9_next;
    logic                  done_reg;
    logic [DATA_WIDTH-1:0] out_reg, out_next;
    logic [RES_W-1:0]      res;
    logic [SAT_W-1:0]      res_w, lim, res_c;

    // Multiply magnitude by 1 +/- tanh
    assign prod9_next = PROD_W'(a_in) * PROD_W'(fac_in);

    // Round half up, pick the large-input case, clip and apply the sign
    always_comb
    begin
        res = RES_W'(((PROD_W + 1)'(prod9_reg) + ((PROD_W + 1)'(1) << (SH - 1))) >> SH);
        if (ctrl9_reg.big)
            res_w = ctrl9_reg.neg ? '0 : SAT_W'(mag9_reg);
        else
            res_w = SAT_W'(res);
        lim = ctrl9_reg.neg ? (SAT_W'(1) << (DATA_WIDTH - 1))
                            : ((SAT_W'(1) << (DATA_WIDTH - 1)) - SAT_W'(1));
        res_c    = (res_w > lim) ? lim : res_w;
        out_next = ctrl9_reg.neg ? DATA_WIDTH'((~res_c) + SAT_W'(1)) : DATA_WIDTH'(res_c);
    end

    // Advance valid bits and the result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl9_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            ctrl9_reg <= ctrl_in;
            done_reg  <= ctrl9_reg.valid;
        end
    end

    // Advance payload
    always_ff @(posedge clk)
    begin
        mag9_reg  <= mag_in;
        prod9_reg <= prod9_next;
        out_reg   <= out_next;
    end

    assign done           = done_reg;
    assign activation_out = out_reg;

    `GTAC_ASSERT_NOW(a_strobe_follows, 1'b1, done == $past(ctrl9_reg.valid))
    `GTAC_ASSERT_NEXT(a_big_neg_zero, ctrl9_reg.valid && ctrl9_reg.big && ctrl9_reg.neg,
        activation_out == '0)
    `GTAC_ASSERT_NEXT(a_big_pos_pass, ctrl9_reg.valid && ctrl9_reg.big && !ctrl9_reg.neg,
        out_reg == $past(mag9_reg))
    `GTAC_ASSERT_NEXT(a_pos_nonneg, ctrl9_reg.valid && !ctrl9_reg.neg,
        !out_reg[DATA_WIDTH-1])

endmodule

FILE: rtl/gelu_tanh_activation_core.sv
// GELU activation, tanh form, signed fixed point, fully pipelined.
// The pipeline has ten register stages, the last of which drives done.
// Throughput: one transaction per cycle; busy stays low, every stage advances each cycle.
// The result is shown for one cycle with done and cannot be held off.
// Reset (rst_n low, asynchronous) clears all valid bits; no clearing pass is needed.
// Depends on gtac_pkg, gtac_poly, gtac_tanh and gtac_out.
module gelu_tanh_activation_core #(
    parameter int DATA_WIDTH    = gtac_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS     = gtac_pkg::FRAC_BITS_DEF,
    parameter int TANH_SEGMENTS = gtac_pkg::TANH_SEGMENTS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic signed [DATA_WIDTH-1:0] sample_in,
    output logic                         done,
    output logic signed [DATA_WIDTH-1:0] activation_out
);

    gtac_pkg::ctrl_t                 poly_ctrl, tanh_ctrl;
    logic [DATA_WIDTH-1:0]           poly_mag, tanh_mag;
    logic [gtac_pkg::A_W-1:0]        poly_a, tanh_a;
    logic [gtac_pkg::Z_W-1:0]        poly_z;
    logic [gtac_pkg::FAC_W-1:0]      tanh_fac;

    // The pipeline never stalls, so a new transaction is always taken
    assign busy = 1'b0;

    gtac_poly #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_poly (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start && !busy),
        .in_sample (sample_in),
        .ctrl_out  (poly_ctrl),
        .mag_out   (poly_mag),
        .a_out     (poly_a),
        .z_out     (poly_z)
    );

    gtac_tanh #(
        .DATA_WIDTH    (DATA_WIDTH),
        .TANH_SEGMENTS (TANH_SEGMENTS)
    ) u_tanh (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl_in  (poly_ctrl),
        .mag_in   (poly_mag),
        .a_in     (poly_a),
        .z_in     (poly_z),
        .ctrl_out (tanh_ctrl),
        .mag_out  (tanh_mag),
        .a_out    (tanh_a),
        .fac_out  (tanh_fac)
    );

    gtac_out #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_out (
        .clk            (clk),
        .rst_n          (rst_n),
        .ctrl_in        (tanh_ctrl),
        .mag_in         (tanh_mag),
        .a_in           (tanh_a),
        .fac_in         (tanh_fac),
        .done           (done),
        .activation_out (activation_out)
    );

endmodule
